// ===== rtl/core/md5_message_digest_defines.svh =====
// Assertion macros shared by the MD5 digest RTL.
`ifndef MD5_MESSAGE_DIGEST_DEFINES_SVH
`define MD5_MESSAGE_DIGEST_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define MD5_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define MD5_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/md5_pkg.sv =====
// Types, constants and round tables for the MD5 digest block.
package md5_pkg;

	localparam logic [31:0] INIT_A = 32'h67452301;
	localparam logic [31:0] INIT_B = 32'hefcdab89;
	localparam logic [31:0] INIT_C = 32'h98badcfe;
	localparam logic [31:0] INIT_D = 32'h10325476;
	localparam logic [3:0][31:0] CHAIN_INIT = {INIT_D, INIT_C, INIT_B, INIT_A};

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] LEN_POS = 6'd56;
	localparam logic [5:0] LAST_POS = 6'd63;
	localparam logic [5:0] LAST_ROUND = 6'd63;
	localparam logic [1:0] LAST_WORD = 2'd3;

	localparam logic [31:0] SINE_TAB [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	typedef enum logic [1:0] {
		MODE_DATA,
		MODE_PAD_A,
		MODE_PAD_B,
		MODE_PAD_AB
	} block_mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ISSUE,
		ST_DRAIN,
		ST_FOLD,
		ST_EMIT
	} seq_state_t;

	typedef struct packed {
		logic [7:0] message_byte;
		logic       has_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [1:0]  word_pos;
		logic        digest_last;
	} digest_t;

	typedef struct packed {
		logic        load;
		logic        mix_valid;
		logic [5:0]  mix_round;
		logic        step_valid;
		logic [5:0]  step_round;
		block_mode_t mode;
		logic        fold;
		logic        init;
	} round_ctrl_t;

	function automatic logic [3:0] msg_index(input logic [5:0] rnd);
		logic [3:0] rl;
		logic [3:0] idx;
		rl = rnd[3:0];
		unique case (rnd[5:4])
			2'd0: idx = rl;
			2'd1: idx = rl * 4'd5 + 4'd1;
			2'd2: idx = rl * 4'd3 + 4'd5;
			2'd3: idx = rl * 4'd7;
		endcase
		return idx;
	endfunction

	function automatic logic [4:0] rot_amount(input logic [5:0] rnd);
		logic [4:0] s;
		unique case ({rnd[5:4], rnd[1:0]})
			4'h0: s = 5'd7;
			4'h1: s = 5'd12;
			4'h2: s = 5'd17;
			4'h3: s = 5'd22;
			4'h4: s = 5'd5;
			4'h5: s = 5'd9;
			4'h6: s = 5'd14;
			4'h7: s = 5'd20;
			4'h8: s = 5'd4;
			4'h9: s = 5'd11;
			4'ha: s = 5'd16;
			4'hb: s = 5'd23;
			4'hc: s = 5'd6;
			4'hd: s = 5'd10;
			4'he: s = 5'd15;
			4'hf: s = 5'd21;
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/core/md5_message_digest.sv =====
// MD5 digest top level: byte intake, round sequencer and digest output register.
// Flow: a data byte is taken while idle; the 64th byte of a block starts a compression
// (load, 64 rounds, drain, fold), all spent on the single shared round unit.
// A last item runs one or two such compressions, then emits four words, one per cycle
// unless digest_ready stalls. No new byte is taken until the compression or emit ends.
// Reset: chaining words to the MD5 initial values, byte count to zero; store contents undefined.
`include "md5_message_digest_defines.svh"

module md5_message_digest #(
	parameter int unsigned COUNT_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  md5_pkg::item_t   item,
	input  logic             item_valid,
	output logic             item_ready,
	output md5_pkg::digest_t digest,
	output logic             digest_valid,
	input  logic             digest_ready
);

	md5_pkg::seq_state_t  state_q;
	md5_pkg::seq_state_t  state_d;
	md5_pkg::block_mode_t mode_q;
	md5_pkg::block_mode_t mode_d;
	md5_pkg::block_mode_t pad_mode_idle;
	md5_pkg::block_mode_t pad_mode_fold;
	md5_pkg::round_ctrl_t ctrl;
	md5_pkg::digest_t     digest_q;

	logic [COUNT_BITS-1:0] byte_count_q;
	logic                  last_q;
	logic [5:0]            rnd_q;
	logic [5:0]            rnd_s1;
	logic [5:0]            rnd_s2;
	logic                  v_s1;
	logic                  v_s2;
	logic [1:0]            widx_q;
	logic                  out_valid_q;
	logic                  accept;
	logic                  full_blk;
	logic [5:0]            pos_next;
	logic                  mem_we;
	logic                  issue;
	logic                  out_load;
	logic                  finish;
	logic [31:0]           rd_data;
	logic [3:0][31:0]      chain;
	logic [63:0]           bit_len;

	assign accept = item_valid && item_ready;
	assign full_blk = item.has_byte && (byte_count_q[5:0] == md5_pkg::LAST_POS);
	assign pos_next = byte_count_q[5:0] + 6'(item.has_byte);
	assign pad_mode_idle = (pos_next >= md5_pkg::LEN_POS) ? md5_pkg::MODE_PAD_A
		: md5_pkg::MODE_PAD_AB;
	assign pad_mode_fold = (byte_count_q[5:0] >= md5_pkg::LEN_POS) ? md5_pkg::MODE_PAD_A
		: md5_pkg::MODE_PAD_AB;
	assign bit_len = 64'({byte_count_q, 3'b000});

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			md5_pkg::ST_IDLE: begin
				if (accept && (full_blk || item.last_byte)) begin
					state_d = md5_pkg::ST_LOAD;
				end
			end
			md5_pkg::ST_LOAD: state_d = md5_pkg::ST_ISSUE;
			md5_pkg::ST_ISSUE: begin
				if (rnd_q == md5_pkg::LAST_ROUND) begin
					state_d = md5_pkg::ST_DRAIN;
				end
			end
			md5_pkg::ST_DRAIN: begin
				if (!v_s1 && !v_s2) begin
					state_d = md5_pkg::ST_FOLD;
				end
			end
			md5_pkg::ST_FOLD: begin
				unique case (mode_q)
					md5_pkg::MODE_DATA:   state_d = last_q ? md5_pkg::ST_LOAD : md5_pkg::ST_IDLE;
					md5_pkg::MODE_PAD_A:  state_d = md5_pkg::ST_LOAD;
					md5_pkg::MODE_PAD_B:  state_d = md5_pkg::ST_EMIT;
					md5_pkg::MODE_PAD_AB: state_d = md5_pkg::ST_EMIT;
				endcase
			end
			md5_pkg::ST_EMIT: begin
				if (out_load && widx_q == md5_pkg::LAST_WORD) begin
					state_d = md5_pkg::ST_IDLE;
				end
			end
			default: state_d = md5_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		item_ready = (state_q == md5_pkg::ST_IDLE);
		mem_we = accept && item.has_byte;
		issue = (state_q == md5_pkg::ST_ISSUE);
		out_load = (state_q == md5_pkg::ST_EMIT) && (!out_valid_q || digest_ready);
		finish = out_load && (widx_q == md5_pkg::LAST_WORD);
		mode_d = mode_q;
		if (accept) begin
			if (full_blk) begin
				mode_d = md5_pkg::MODE_DATA;
			end else if (item.last_byte) begin
				mode_d = pad_mode_idle;
			end
		end else if (state_q == md5_pkg::ST_FOLD) begin
			if (mode_q == md5_pkg::MODE_DATA) begin
				mode_d = pad_mode_fold;
			end else if (mode_q == md5_pkg::MODE_PAD_A) begin
				mode_d = md5_pkg::MODE_PAD_B;
			end
		end
		ctrl.load = (state_q == md5_pkg::ST_LOAD);
		ctrl.mix_valid = v_s1;
		ctrl.mix_round = rnd_s1;
		ctrl.step_valid = v_s2;
		ctrl.step_round = rnd_s2;
		ctrl.mode = mode_q;
		ctrl.fold = (state_q == md5_pkg::ST_FOLD);
		ctrl.init = finish;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= md5_pkg::ST_IDLE;
			mode_q <= md5_pkg::MODE_DATA;
			last_q <= 1'b0;
			byte_count_q <= '0;
			rnd_q <= '0;
			rnd_s1 <= '0;
			rnd_s2 <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			widx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			mode_q <= mode_d;
			if (accept) begin
				last_q <= item.last_byte;
			end
			if (finish) begin
				byte_count_q <= '0;
			end else if (mem_we) begin
				byte_count_q <= byte_count_q + COUNT_BITS'(1);
			end
			if (ctrl.load) begin
				rnd_q <= '0;
			end else if (issue) begin
				rnd_q <= rnd_q + 6'd1;
			end
			v_s1 <= issue;
			rnd_s1 <= rnd_q;
			v_s2 <= v_s1;
			rnd_s2 <= rnd_s1;
			if (out_load) begin
				widx_q <= widx_q + 2'd1;
				out_valid_q <= 1'b1;
			end else if (digest_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			digest_q.digest_word <= chain[widx_q];
			digest_q.word_pos <= widx_q;
			digest_q.digest_last <= (widx_q == md5_pkg::LAST_WORD);
		end
	end

	assign digest = digest_q;
	assign digest_valid = out_valid_q;

	md5_msg_mem u_mem (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (byte_count_q[5:0]),
		.wr_data (item.message_byte),
		.rd_en   (issue),
		.rd_addr (md5_pkg::msg_index(rnd_q)),
		.rd_data (rd_data)
	);

	md5_round_unit u_round (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.rd_data (rd_data),
		.pad_pos (byte_count_q[5:0]),
		.bit_len (bit_len),
		.chain   (chain)
	);

	`MD5_ASSERT_NOW(a_fold_drained, state_q == md5_pkg::ST_FOLD, !v_s1 && !v_s2,
		"fold while rounds in flight")
	`MD5_ASSERT_NOW(a_step_in_block, v_s2,
		state_q == md5_pkg::ST_ISSUE || state_q == md5_pkg::ST_DRAIN,
		"round step outside a compression")
	`MD5_ASSERT_NEXT(a_last_busy, item_valid && item_ready && item.last_byte, !item_ready,
		"intake open right after last item")
	`MD5_ASSERT_NEXT(a_word_follow, digest_valid && digest_ready && !digest.digest_last,
		digest_valid, "gap between digest words")

endmodule

// ===== rtl/core/md5_msg_mem.sv =====
// Block store: 16 words of message bytes, byte-wide write, registered word read.
module md5_msg_mem (
	input  logic        clk,
	input  logic        wr_en,
	input  logic [5:0]  wr_addr,
	input  logic [7:0]  wr_data,
	input  logic        rd_en,
	input  logic [3:0]  rd_addr,
	output logic [31:0] rd_data
);

	logic [31:0] mem_q [16];
	logic [31:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr[5:2]][{wr_addr[1:0], 3'b000} +: 8] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/core/md5_round_unit.sv =====
// Shared MD5 round datapath: padding mux, constant add, one round per step, chaining fold.
module md5_round_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  md5_pkg::round_ctrl_t ctrl,
	input  logic [31:0]         rd_data,
	input  logic [5:0]          pad_pos,
	input  logic [63:0]         bit_len,
	output logic [3:0][31:0]    chain
);

	logic [3:0][31:0] chain_q;
	logic [31:0]      a_q;
	logic [31:0]      b_q;
	logic [31:0]      c_q;
	logic [31:0]      d_q;
	logic [31:0]      km_s2;
	logic [3:0]       word_idx;
	logic [3:0][5:0]  byte_pos;
	logic [3:0][7:0]  pad_byte;
	logic [3:0][7:0]  len_byte;
	logic [3:0]       in_len;
	logic [31:0]      msg_word;
	logic [31:0]      f_val;
	logic [31:0]      t_val;
	logic [4:0]       shamt;
	logic [63:0]      rot_wide;

	always_comb begin
		word_idx = md5_pkg::msg_index(ctrl.mix_round);
		for (int j = 0; j < 4; j++) begin
			byte_pos[j] = {word_idx, 2'(j)};
			if (byte_pos[j] < pad_pos) begin
				pad_byte[j] = rd_data[8*j +: 8];
			end else if (byte_pos[j] == pad_pos) begin
				pad_byte[j] = md5_pkg::PAD_MARK;
			end else begin
				pad_byte[j] = 8'h00;
			end
			len_byte[j] = bit_len[{byte_pos[j][2:0], 3'b000} +: 8];
			in_len[j] = (byte_pos[j] >= md5_pkg::LEN_POS);
			unique case (ctrl.mode)
				md5_pkg::MODE_DATA:   msg_word[8*j +: 8] = rd_data[8*j +: 8];
				md5_pkg::MODE_PAD_A:  msg_word[8*j +: 8] = pad_byte[j];
				md5_pkg::MODE_PAD_B:  msg_word[8*j +: 8] = in_len[j] ? len_byte[j] : 8'h00;
				md5_pkg::MODE_PAD_AB: msg_word[8*j +: 8] = in_len[j] ? len_byte[j] : pad_byte[j];
			endcase
		end
	end

	always_comb begin
		unique case (ctrl.step_round[5:4])
			2'd0: f_val = (b_q & c_q) | (~b_q & d_q);
			2'd1: f_val = (d_q & b_q) | (~d_q & c_q);
			2'd2: f_val = b_q ^ c_q ^ d_q;
			2'd3: f_val = c_q ^ (b_q | ~d_q);
		endcase
		t_val = a_q + f_val + km_s2;
		shamt = md5_pkg::rot_amount(ctrl.step_round);
		rot_wide = {t_val, t_val} << shamt;
	end

	always_ff @(posedge clk) begin
		if (ctrl.mix_valid) begin
			km_s2 <= md5_pkg::SINE_TAB[ctrl.mix_round] + msg_word;
		end
		if (ctrl.load) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
		end else if (ctrl.step_valid) begin
			a_q <= d_q;
			b_q <= b_q + rot_wide[63:32];
			c_q <= b_q;
			d_q <= c_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= md5_pkg::CHAIN_INIT;
		end else if (ctrl.init) begin
			chain_q <= md5_pkg::CHAIN_INIT;
		end else if (ctrl.fold) begin
			chain_q[0] <= chain_q[0] + a_q;
			chain_q[1] <= chain_q[1] + b_q;
			chain_q[2] <= chain_q[2] + c_q;
			chain_q[3] <= chain_q[3] + d_q;
		end
	end

	assign chain = chain_q;

endmodule

// ===== tb/md5_message_digest_tb.sv =====
// Self-checking testbench for md5_message_digest: random byte messages against an MD5 model.
`timescale 1ns / 1ps

localparam int unsigned MSG_COUNT_BITS = 32;

localparam logic [31:0] MD5_SINES [64] = '{
	32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
	32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
	32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
	32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
	32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
	32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
	32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
	32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
	32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
	32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
	32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
	32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
	32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
	32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
	32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
	32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
};

localparam int MD5_ROT_AMTS [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

class digest_book;
	logic [31:0] chain [4];
	logic [7:0] blk [64];
	logic [MSG_COUNT_BITS-1:0] nbytes;
	md5_pkg::digest_t owed_words [$];
	int mismatches;

	function new();
		mismatches = 0;
		restart();
		foreach (blk[k]) blk[k] = 8'h00;
	endfunction

	function void restart();
		chain[0] = 32'h67452301;
		chain[1] = 32'hefcdab89;
		chain[2] = 32'h98badcfe;
		chain[3] = 32'h10325476;
		nbytes = '0;
	endfunction

	task flag_mismatch(string msg);
		$display("%0t MISMATCH: %s", $time, msg);
		mismatches++;
	endtask

	function void crunch();
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, f, t, hold;
		int g, s;
		for (int r = 0; r < 16; r++) begin
			w[r] = {blk[4*r+3], blk[4*r+2], blk[4*r+1], blk[4*r]};
		end
		a = chain[0];
		b = chain[1];
		c = chain[2];
		d = chain[3];
		for (int r = 0; r < 64; r++) begin
			case (r / 16)
				0: begin
					f = (b & c) | (~b & d);
					g = r;
				end
				1: begin
					f = (d & b) | (~d & c);
					g = (5 * r + 1) % 16;
				end
				2: begin
					f = b ^ c ^ d;
					g = (3 * r + 5) % 16;
				end
				default: begin
					f = c ^ (b | ~d);
					g = (7 * r) % 16;
				end
			endcase
			t = a + f + MD5_SINES[r] + w[g];
			s = MD5_ROT_AMTS[(r / 16) * 4 + r % 4];
			hold = d;
			d = c;
			c = b;
			b = b + ((t << s) | (t >> (32 - s)));
			a = hold;
		end
		chain[0] += a;
		chain[1] += b;
		chain[2] += c;
		chain[3] += d;
	endfunction

	function void absorb(md5_pkg::item_t it);
		logic [63:0] bit_len;
		md5_pkg::digest_t w;
		int pos;
		if (it.has_byte) begin
			pos = int'(nbytes[5:0]);
			blk[pos] = it.message_byte;
			nbytes = nbytes + 1'b1;
			if (pos == 63)
				crunch();
		end
		if (!it.last_byte)
			return;
		pos = int'(nbytes[5:0]);
		blk[pos] = 8'h80;
		for (int k = pos + 1; k < 64; k++) blk[k] = 8'h00;
		if (pos >= 56) begin
			crunch();
			for (int k = 0; k < 56; k++) blk[k] = 8'h00;
		end
		bit_len = 64'(nbytes) << 3;
		for (int k = 0; k < 8; k++) blk[56+k] = bit_len[8*k +: 8];
		crunch();
		for (int k = 0; k < 4; k++) begin
			w.digest_word = chain[k];
			w.word_pos = 2'(k);
			w.digest_last = (k == 3);
			owed_words.push_back(w);
		end
		restart();
	endfunction

	task match_word(md5_pkg::digest_t got);
		md5_pkg::digest_t want;
		if (owed_words.size() == 0) begin
			flag_mismatch($sformatf("unexpected digest word %h index %0d",
				got.digest_word, got.word_pos));
			return;
		end
		want = owed_words.pop_front();
		if (got.digest_word !== want.digest_word)
			flag_mismatch($sformatf("digest_word %h, want %h (index %0d)",
				got.digest_word, want.digest_word, want.word_pos));
		if (got.word_pos !== want.word_pos)
			flag_mismatch($sformatf("word_pos %0d, want %0d",
				got.word_pos, want.word_pos));
		if (got.digest_last !== want.digest_last)
			flag_mismatch($sformatf("digest_last %b, want %b (index %0d)",
				got.digest_last, want.digest_last, want.word_pos));
	endtask
endclass

module md5_message_digest_tb;

	localparam int HOLD_CYCLES = 600;
	localparam int ITEM_TARGET = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	md5_pkg::item_t item = '0;
	logic item_valid = 1'b0;
	logic item_ready;
	md5_pkg::digest_t digest;
	logic digest_valid;
	logic digest_ready = 1'b0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_req = 1'b0;
	int sent_items = 0;

	digest_book digests = new();

	md5_message_digest #(
		.COUNT_BITS(MSG_COUNT_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.digest(digest),
		.digest_valid(digest_valid),
		.digest_ready(digest_ready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic offer(input logic [7:0] b, input logic has, input logic last);
		md5_pkg::item_t it;
		it = '{message_byte: b, has_byte: has, last_byte: last};
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		digests.absorb(it);
		sent_items++;
	endtask

	task automatic send_message(input int len, input bit tail_empty);
		if (len == 0) begin
			offer(8'($urandom), 1'b0, 1'b1);
			return;
		end
		for (int k = 0; k < len; k++) begin
			if ($urandom_range(15) == 0)
				offer(8'($urandom), 1'b0, 1'b0);
			offer(8'($urandom), 1'b1, (k == len - 1) && !tail_empty);
		end
		if (tail_empty)
			offer(8'($urandom), 1'b0, 1'b1);
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (digest_valid && digest_ready)
					digests.match_word(digest);
				if (hold_req) begin
					digest_ready <= 1'b0;
					repeat (HOLD_CYCLES) @(posedge clk);
					hold_req = 1'b0;
				end else begin
					digest_ready <= ($urandom_range(99) >= recv_stall_pct);
				end
			end
		end
	end

	initial begin
		int msg_no;
		int len;
		int waited;
		int edges [5];
		edges = '{55, 56, 63, 64, 65};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer(8'hA5, 1'b0, 1'b1);
		offer(8'h61, 1'b1, 1'b0);
		offer(8'h62, 1'b1, 1'b0);
		offer(8'h63, 1'b1, 1'b1);
		offer(8'h00, 1'b1, 1'b0);
		offer(8'hFF, 1'b1, 1'b0);
		offer(8'h5A, 1'b0, 1'b0);
		offer(8'hC3, 1'b0, 1'b1);
		offer(8'hFF, 1'b1, 1'b1);
		offer(8'h00, 1'b1, 1'b1);
		offer(8'hFF, 1'b0, 1'b0);
		offer(8'h00, 1'b0, 1'b1);

		msg_no = 0;
		while (sent_items < ITEM_TARGET) begin
			case ((sent_items * 4) / ITEM_TARGET)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 75;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 75;
				end
				default: begin
					send_idle_pct = 33;
					recv_stall_pct = 33;
				end
			endcase
			if (msg_no == 1)
				hold_req = 1'b1;
			if ($urandom_range(3) == 0)
				len = edges[$urandom_range(4)];
			else
				len = $urandom_range(24);
			send_message(len, $urandom_range(1));
			msg_no++;
		end
		item_valid <= 1'b0;

		waited = 0;
		while (digests.owed_words.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		if (digests.owed_words.size() != 0)
			digests.flag_mismatch($sformatf("%0d digest words never arrived",
				digests.owed_words.size()));
		repeat (200) @(posedge clk);
		if (digests.mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#10000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
